// ===== src/hbue_pkg.sv =====
// Shared constants, control-word types and the microcode program of the histogram core.
package hbue_pkg;

    localparam int NUM_BINS = 256;
    localparam int IDX_W    = $clog2(NUM_BINS);
    localparam int CNT_W    = $clog2(NUM_BINS + 1);
    localparam int DATA_W   = 32;
    localparam int REP_W    = 8;   // reported index width
    localparam int WIN_W    = 9;   // bins_in_use register width
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE  = CFG_IDX_W'(1);

    localparam logic [WIN_W-1:0] BINS_IN_USE_RST = WIN_W'(256);

    // Program steps
    typedef logic [2:0] t_step;
    localparam t_step STEP_IDLE      = 3'd0;
    localparam t_step STEP_CHECK     = 3'd1;
    localparam t_step STEP_WRITE     = 3'd2;
    localparam t_step STEP_SCAN_INIT = 3'd3;
    localparam t_step STEP_SCAN      = 3'd4;
    localparam t_step STEP_DRAIN     = 3'd5;
    localparam t_step STEP_EMIT      = 3'd6;

    // Jump conditions
    typedef enum logic [2:0] {
        COND_NONE,
        COND_NO_IN,
        COND_REJECT,
        COND_NO_BINS,
        COND_SCAN_MORE,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        logic  ld_in;
        logic  rd_bin;
        logic  wr_bin;
        logic  scan_clr;
        logic  scan_rd;
        logic  emit;
        t_cond cond;
        t_step target;
        logic  restart;   // fall-through returns to the idle step
    } t_ucode;

    typedef struct packed {
        logic in_valid;
        logic reject;
        logic no_bins;
        logic scan_more;
        logic out_busy;
    } t_status;

    localparam t_ucode UC_NOP = '{ld_in: 1'b0, rd_bin: 1'b0, wr_bin: 1'b0,
                                  scan_clr: 1'b0, scan_rd: 1'b0, emit: 1'b0,
                                  cond: COND_NONE, target: STEP_IDLE, restart: 1'b0};

    function automatic t_ucode ucode_rom(input t_step step);
        t_ucode w;
        w = UC_NOP;
        case (step)
            STEP_IDLE: begin
                w.ld_in  = 1'b1;
                w.cond   = COND_NO_IN;
                w.target = STEP_IDLE;
            end
            STEP_CHECK: begin
                w.rd_bin = 1'b1;
                w.cond   = COND_REJECT;
                w.target = STEP_SCAN_INIT;
            end
            STEP_WRITE: begin
                w.wr_bin = 1'b1;
            end
            STEP_SCAN_INIT: begin
                w.scan_clr = 1'b1;
                w.cond     = COND_NO_BINS;
                w.target   = STEP_EMIT;
            end
            STEP_SCAN: begin
                w.scan_rd = 1'b1;
                w.cond    = COND_SCAN_MORE;
                w.target  = STEP_SCAN;
            end
            STEP_DRAIN: begin
                w = UC_NOP;
            end
            STEP_EMIT: begin
                w.emit    = 1'b1;
                w.cond    = COND_OUT_BUSY;
                w.target  = STEP_EMIT;
                w.restart = 1'b1;
            end
            default: begin
                w.restart = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== src/histogram_bin_update_extent_core.sv =====
// Top level of the histogram bin counter with nonzero-extent scan.
//
// Input channel (i_in_valid / o_in_ready) takes one word: a signed sample value
// and a signed count delta. The value maps to bin (value - window_start); a
// value outside [0, bins_in_use) is flagged and leaves the bins unchanged.
// Output channel (o_out_valid / i_out_ready) returns one word per input: the
// out-of-window flag, whether any active bin is nonzero, the lowest and
// highest nonzero bin index, and the wrapping sum of all active bins.
// Config channel (i_cfg_valid / o_cfg_ready, ready whenever out of reset):
// index 0 is window_start, index 1 is bins_in_use (low 9 bits, clamped to
// 256); other indexes are dropped. Write only while no word is in flight.
// Sequence: a microcoded sequencer walks check, read-modify-write, then a scan
// of the single-port bin memory, one bin per cycle, and then emits the result.
// A rejected word skips the write. The next word is taken only after the
// previous result has been emitted into the output register.
// Reset (synchronous, active low) zeroes the bins at once through per-bin
// valid flags; there is no clearing sweep. A stalled receiver holds the
// result in the output register; the next word is still accepted and worked
// on, and the core waits only at its emit step until the register frees.
module histogram_bin_update_extent_core
    import hbue_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [DATA_W-1:0]    i_sample_value,
    input  logic [DATA_W-1:0]    i_count_delta,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_out_of_window,
    output logic                 o_any_nonzero,
    output logic [REP_W-1:0]     o_first_nonzero,
    output logic [REP_W-1:0]     o_last_nonzero,
    output logic [DATA_W-1:0]    o_total_count,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    t_ucode  ctrl;
    t_status status;

    // Sequencer fetches one control word per step
    hbue_ucode_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    hbue_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .o_status        (status),
        .i_in_valid      (i_in_valid),
        .i_sample_value  (i_sample_value),
        .i_count_delta   (i_count_delta),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_out_of_window (o_out_of_window),
        .o_any_nonzero   (o_any_nonzero),
        .o_first_nonzero (o_first_nonzero),
        .o_last_nonzero  (o_last_nonzero),
        .o_total_count   (o_total_count)
    );

    // Only the idle step takes a new word; nothing is taken during reset
    assign o_in_ready  = ctrl.ld_in && i_rst_n;
    assign o_cfg_ready = i_rst_n;

endmodule

// ===== src/hbue_bin_ram.sv =====
// Single-port bin memory with registered read data.
module hbue_bin_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_addr];
        end
    end

endmodule

// ===== src/hbue_ucode_seq.sv =====
// Microcode sequencer: step counter, program ROM and conditional jumps.
module hbue_ucode_seq
    import hbue_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_ucode  o_ctrl
);

    t_step  r_pc;
    t_step  n_pc;
    t_ucode word;
    logic   cond_true;

    assign word   = ucode_rom(r_pc);
    assign o_ctrl = word;

    always_comb begin
        case (word.cond)
            COND_NONE:      cond_true = 1'b0;
            COND_NO_IN:     cond_true = !i_status.in_valid;
            COND_REJECT:    cond_true = i_status.reject;
            COND_NO_BINS:   cond_true = i_status.no_bins;
            COND_SCAN_MORE: cond_true = i_status.scan_more;
            COND_OUT_BUSY:  cond_true = i_status.out_busy;
            default:        cond_true = 1'b0;
        endcase
        if (cond_true) begin
            n_pc = word.target;
        end else if (word.restart) begin
            n_pc = STEP_IDLE;
        end else begin
            n_pc = r_pc + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== src/hbue_datapath.sv =====
// Datapath: config registers, window test, bin update, extent scan and result register.
module hbue_datapath
    import hbue_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ucode               i_ctrl,
    output t_status              o_status,
    input  logic                 i_in_valid,
    input  logic [DATA_W-1:0]    i_sample_value,
    input  logic [DATA_W-1:0]    i_count_delta,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_out_of_window,
    output logic                 o_any_nonzero,
    output logic [REP_W-1:0]     o_first_nonzero,
    output logic [REP_W-1:0]     o_last_nonzero,
    output logic [DATA_W-1:0]    o_total_count
);

    logic [DATA_W-1:0] r_window_start;
    logic [WIN_W-1:0]  r_bins_in_use;
    logic [CNT_W-1:0]  n_active;
    logic [DATA_W:0]   offset;
    logic              in_win;

    logic              r_reject;
    logic [IDX_W-1:0]  r_idx;
    logic [DATA_W-1:0] r_delta;

    logic [NUM_BINS-1:0] r_valid;
    logic              r_rd_vld;
    logic [DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0] rd_word;
    logic [IDX_W-1:0]  ram_addr;
    logic              ram_re;

    logic [CNT_W-1:0]  r_scan;
    logic              r_acc_pend;
    logic [IDX_W-1:0]  r_acc_idx;
    logic [DATA_W-1:0] r_sum;
    logic              r_found;
    logic [IDX_W-1:0]  r_first;
    logic [IDX_W-1:0]  r_last;

    logic              r_out_valid;
    logic              out_busy;
    logic              emit_en;

    // Active bin count, clamped to the built size
    always_comb begin
        if (int'(r_bins_in_use) > NUM_BINS) begin
            n_active = CNT_W'(NUM_BINS);
        end else begin
            n_active = CNT_W'(r_bins_in_use);
        end
    end

    // Full-width offset, so the window end never overflows
    assign offset = {i_sample_value[DATA_W-1], i_sample_value}
                  - {r_window_start[DATA_W-1], r_window_start};
    assign in_win = !offset[DATA_W] && (offset < (DATA_W+1)'(n_active));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_start <= '0;
            r_bins_in_use  <= BINS_IN_USE_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_WINDOW_START) begin
                r_window_start <= i_cfg_data;
            end else if (i_cfg_index == REG_BINS_IN_USE) begin
                r_bins_in_use <= i_cfg_data[WIN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_in && i_in_valid) begin
            r_reject <= !in_win;
            r_idx    <= offset[IDX_W-1:0];
            r_delta  <= i_count_delta;
        end
    end

    // Bin store; entries never written read as zero
    assign ram_re   = i_ctrl.rd_bin || i_ctrl.scan_rd;
    assign ram_addr = i_ctrl.scan_rd ? r_scan[IDX_W-1:0] : r_idx;
    assign rd_word  = r_rd_vld ? ram_rdata : '0;

    hbue_bin_ram #(
        .DEPTH (NUM_BINS),
        .WIDTH (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.wr_bin),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (rd_word + r_delta),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctrl.wr_bin) begin
            r_valid[r_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_rd_vld <= r_valid[ram_addr];
        end
    end

    // Extent scan: read issued one cycle, accumulated the next
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_pend <= 1'b0;
        end else begin
            r_acc_pend <= i_ctrl.scan_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.scan_rd) begin
            r_acc_idx <= r_scan[IDX_W-1:0];
        end
        if (i_ctrl.scan_clr) begin
            r_scan  <= '0;
            r_sum   <= '0;
            r_found <= 1'b0;
            r_first <= '0;
            r_last  <= '0;
        end else begin
            if (i_ctrl.scan_rd) begin
                r_scan <= r_scan + CNT_W'(1);
            end
            if (r_acc_pend) begin
                r_sum <= r_sum + rd_word;
                if (rd_word != '0) begin
                    if (!r_found) begin
                        r_first <= r_acc_idx;
                    end
                    r_found <= 1'b1;
                    r_last  <= r_acc_idx;
                end
            end
        end
    end

    // Result register
    assign out_busy = r_out_valid && !i_out_ready;
    assign emit_en  = i_ctrl.emit && !out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_en) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_en) begin
            o_out_of_window <= r_reject;
            o_any_nonzero   <= r_found;
            o_first_nonzero <= REP_W'(r_first);
            o_last_nonzero  <= REP_W'(r_last);
            o_total_count   <= r_sum;
        end
    end

    assign o_out_valid = r_out_valid;

    assign o_status.in_valid  = i_in_valid;
    assign o_status.reject    = r_reject;
    assign o_status.no_bins   = (n_active == '0);
    assign o_status.scan_more = ({1'b0, r_scan} + (CNT_W+1)'(1)) < {1'b0, n_active};
    assign o_status.out_busy  = out_busy;

endmodule

// ===== src/hbue_checker.sv =====
// Port-level checker for the histogram core, with its bind.
module hbue_checker
    import hbue_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_any_nonzero,
    input logic [REP_W-1:0]  o_first_nonzero,
    input logic [REP_W-1:0]  o_last_nonzero,
    input logic [DATA_W-1:0] o_total_count
);

    // Each word takes several steps before another is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken on consecutive cycles");

    // Empty histogram reports zero indices and a zero sum
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_any_nonzero) |->
            (o_first_nonzero == '0 && o_last_nonzero == '0 && o_total_count == '0))
        else $error("empty result carries nonzero fields");

    // Extent is ordered
    a_extent_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_any_nonzero) |-> (o_first_nonzero <= o_last_nonzero))
        else $error("first nonzero above last nonzero");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_total_count) && $stable(o_first_nonzero)))
        else $error("stalled result changed");

endmodule

bind histogram_bin_update_extent_core hbue_checker u_hbue_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_any_nonzero   (o_any_nonzero),
    .o_first_nonzero (o_first_nonzero),
    .o_last_nonzero  (o_last_nonzero),
    .o_total_count   (o_total_count)
);
